// ----- rtl/kcp_pkg.sv -----
// kcp_pkg: shared types and constants for the k-means color pass block.
// Holds field widths, the item command code, the queue entry and the engine state type.
// No dependencies.
package kcp_pkg;

  localparam int CHAN_W    = 8;
  localparam int CID_W     = 4;
  localparam int CFG_W     = 5;
  localparam int MCOUNT_W  = 23;
  localparam int DIST_W    = 18;
  localparam int CENT_W    = 3 * CHAN_W;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_PIXEL,
    CMD_DROP
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CID_W-1:0]  slot;
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    logic              last;
  } item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_ACC,
    ST_S1_RD,
    ST_S1_DIV,
    ST_S1_WR,
    ST_S2_RD,
    ST_S2_EMIT
  } state_t;

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] e;
    e = (a > b) ? (a - b) : (b - a);
    return {{CHAN_W{1'b0}}, e} * {{CHAN_W{1'b0}}, e};
  endfunction

endpackage

// ----- rtl/kcp_in_if.sv -----
// kcp_in_if: input channel carrying load and pixel beats.
// Depends on kcp_pkg for field widths.
interface kcp_in_if import kcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [CID_W-1:0]  cluster_index;
  logic [CHAN_W-1:0] chan0;
  logic [CHAN_W-1:0] chan1;
  logic [CHAN_W-1:0] chan2;
  logic              last;

  modport source (output valid, operation, cluster_index, chan0, chan1, chan2, last,
                  input ready);
  modport sink   (input valid, operation, cluster_index, chan0, chan1, chan2, last,
                  output ready);
endinterface

// ----- rtl/kcp_out_if.sv -----
// kcp_out_if: result channel carrying one updated centroid per beat.
// Depends on kcp_pkg for field widths.
interface kcp_out_if import kcp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CID_W-1:0]    cluster_id;
  logic [CHAN_W-1:0]   mean0;
  logic [CHAN_W-1:0]   mean1;
  logic [CHAN_W-1:0]   mean2;
  logic [MCOUNT_W-1:0] member_count;
  logic                converged;
  logic                overflow;
  logic                final_result;

  modport source (output valid, cluster_id, mean0, mean1, mean2, member_count,
                  converged, overflow, final_result, input ready);
  modport sink   (input valid, cluster_id, mean0, mean1, mean2, member_count,
                  converged, overflow, final_result, output ready);
endinterface

// ----- rtl/kcp_queue.sv -----
// kcp_queue: front end; accepts input beats, classifies them and holds them
// in a two-entry queue for the engine. Depends on kcp_pkg and kcp_in_if.
module kcp_queue import kcp_pkg::*; #(
  parameter int MAX_CLUSTERS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  kcp_in_if.sink   in_bus,
  output logic     q_valid,
  output item_t    q_item,
  input  logic     q_pop
);

  item_t       ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  item_t       cls;

  assign in_bus.ready = (cnt_r != 2'd2);
  assign push         = in_bus.valid && in_bus.ready;
  assign q_valid      = (cnt_r != 2'd0);
  assign q_item       = ent_r[rd_ptr_r];

  always_comb begin
    cls.slot = in_bus.cluster_index;
    cls.c0   = in_bus.chan0;
    cls.c1   = in_bus.chan1;
    cls.c2   = in_bus.chan2;
    cls.last = in_bus.last;
    if (in_bus.operation) begin
      cls.cmd = CMD_PIXEL;
    end else if (32'(in_bus.cluster_index) < 32'(MAX_CLUSTERS)) begin
      cls.cmd = CMD_LOAD;
    end else begin
      cls.cmd = CMD_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- rtl/kcp_divider.sv -----
// kcp_divider: restoring divider, one quotient bit per cycle, with round to
// nearest, ties to even, and saturation to one channel. Depends on kcp_pkg.
module kcp_divider import kcp_pkg::*; #(
  parameter int SUM_W = 30,
  parameter int CNT_W = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [CHAN_W-1:0] quo
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  num_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              rnd_r;
  logic              done_r;
  logic [CHAN_W-1:0] res_r;
  logic [CNT_W:0]    sh;
  logic              ge;
  logic [CNT_W:0]    twice;
  logic              up;
  logic [SUM_W:0]    q1;

  assign sh    = {rem_r, num_r[SUM_W-1]};
  assign ge    = (sh >= {1'b0, div_r});
  assign twice = {rem_r, 1'b0};
  assign up    = (twice > {1'b0, div_r}) || ((twice == {1'b0, div_r}) && quo_r[0]);
  assign q1    = {1'b0, quo_r} + (SUM_W + 1)'(up);
  assign done  = done_r;
  assign quo   = res_r;

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[SUM_W-2:0], 1'b0};
      rem_r <= ge ? CNT_W'(sh - {1'b0, div_r}) : CNT_W'(sh);
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
    if (rnd_r) begin
      res_r <= (q1 > (SUM_W + 1)'(255)) ? CHAN_W'(255) : q1[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= rnd_r;
      rnd_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/kcp_engine.sv -----
// kcp_engine: back end; nearest-centroid search, accumulation and the
// end-of-pass update and emit sweeps. Depends on kcp_pkg, kcp_out_if, kcp_divider.
module kcp_engine import kcp_pkg::*; #(
  parameter int MAX_CLUSTERS     = 16,
  parameter int PIXEL_COUNT_BITS = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] cluster_count,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  kcp_out_if.source        out_bus
);

  localparam int IDXW = $clog2(MAX_CLUSTERS);
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int CNTW = PIXEL_COUNT_BITS + 1;
  localparam int SUMW = PIXEL_COUNT_BITS + 8;
  localparam int ROWW = CNTW + 3 * SUMW;

  logic [ROWW-1:0]   row_mem  [MAX_CLUSTERS];
  logic [CENT_W-1:0] cent_mem [MAX_CLUSTERS];

  state_t            state_r, state_nxt;
  logic [IDXW-1:0]   idx_r;
  logic [KW-1:0]     sidx_r;
  logic              cmp_vld_r;
  logic [IDXW-1:0]   cmp_idx_r;
  logic [IDXW-1:0]   best_r;
  logic [DIST_W-1:0] best_d_r;
  logic              best_vld_r;
  item_t             item_r;
  logic [CNTW-1:0]   tot_r;
  logic              ovf_r;
  logic              same_r;
  logic [1:0]        ch_r;
  logic              pend_r;
  logic [CHAN_W-1:0] mean_r [3];

  logic              row_we, row_re;
  logic [IDXW-1:0]   row_wa, row_ra;
  logic [ROWW-1:0]   row_wd, row_q;
  logic              cent_we, cent_re;
  logic [IDXW-1:0]   cent_wa, cent_ra;
  logic [CENT_W-1:0] cent_wd, cent_q;

  logic [KW-1:0]     k;
  logic              out_free, out_load, in_k, k_last, is_last_idx, search_more;
  logic [CNTW-1:0]   row_cnt;
  logic [SUMW-1:0]   row_sum [3];
  logic [CHAN_W-1:0] cent_ch [3];
  logic [DIST_W-1:0] cand_d;
  logic              div_start, div_done;
  logic [CHAN_W-1:0] div_q;

  logic              out_valid_r;
  logic [CID_W-1:0]  o_cid_r;
  logic [CHAN_W-1:0] o_m0_r, o_m1_r, o_m2_r;
  logic [MCOUNT_W-1:0] o_cnt_r;
  logic              o_conv_r, o_ovf_r, o_fin_r;

  always_comb begin
    if (cluster_count == '0) begin
      k = KW'(1);
    end else if (32'(cluster_count) > 32'(MAX_CLUSTERS)) begin
      k = KW'(MAX_CLUSTERS);
    end else begin
      k = KW'(cluster_count);
    end
  end

  assign row_cnt    = row_q[ROWW-1 -: CNTW];
  assign row_sum[0] = row_q[0 +: SUMW];
  assign row_sum[1] = row_q[SUMW +: SUMW];
  assign row_sum[2] = row_q[2*SUMW +: SUMW];
  assign cent_ch[0] = cent_q[0 +: CHAN_W];
  assign cent_ch[1] = cent_q[CHAN_W +: CHAN_W];
  assign cent_ch[2] = cent_q[2*CHAN_W +: CHAN_W];

  assign cand_d = DIST_W'(sq_diff(item_r.c0, cent_ch[0])) +
                  DIST_W'(sq_diff(item_r.c1, cent_ch[1])) +
                  DIST_W'(sq_diff(item_r.c2, cent_ch[2]));

  assign out_free    = !out_valid_r || out_bus.ready;
  assign is_last_idx = (idx_r == IDXW'(MAX_CLUSTERS - 1));
  assign in_k        = (32'(idx_r) < 32'(k));
  assign k_last      = ((32'(idx_r) + 32'd1) == 32'(k));
  assign search_more = (32'(sidx_r) < 32'(k));

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (row_re) begin
      row_q <= row_mem[row_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cent_we) begin
      cent_mem[cent_wa] <= cent_wd;
    end
    if (cent_re) begin
      cent_q <= cent_mem[cent_ra];
    end
  end

  kcp_divider #(.SUM_W(SUMW), .CNT_W(CNTW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (row_sum[ch_r]),
    .divisor  (row_cnt),
    .done     (div_done),
    .quo      (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    row_we    = 1'b0;
    row_wa    = idx_r;
    row_wd    = '0;
    row_re    = 1'b0;
    row_ra    = idx_r;
    cent_we   = 1'b0;
    cent_wa   = idx_r;
    cent_wd   = {mean_r[2], mean_r[1], mean_r[0]};
    cent_re   = 1'b0;
    cent_ra   = idx_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        row_we = 1'b1;
        if (is_last_idx) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.cmd)
            CMD_LOAD: begin
              cent_we = 1'b1;
              cent_wa = IDXW'(q_item.slot);
              cent_wd = {q_item.c2, q_item.c1, q_item.c0};
            end
            CMD_PIXEL: state_nxt = ST_SEARCH;
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (search_more) begin
          cent_re = 1'b1;
          cent_ra = sidx_r[IDXW-1:0];
        end else if (!cmp_vld_r) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        row_re    = 1'b1;
        row_ra    = best_r;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (!tot_r[CNTW-1]) begin
          row_we = 1'b1;
          row_wa = best_r;
          row_wd = {row_cnt + CNTW'(1),
                    row_sum[2] + SUMW'(item_r.c2),
                    row_sum[1] + SUMW'(item_r.c1),
                    row_sum[0] + SUMW'(item_r.c0)};
        end
        state_nxt = item_r.last ? ST_S1_RD : ST_IDLE;
      end
      ST_S1_RD: begin
        row_re    = 1'b1;
        cent_re   = 1'b1;
        state_nxt = ST_S1_DIV;
      end
      ST_S1_DIV: begin
        if (row_cnt == '0) begin
          state_nxt = ST_S1_WR;
        end else if (!pend_r) begin
          div_start = 1'b1;
        end else if (div_done && (ch_r == 2'd2)) begin
          state_nxt = ST_S1_WR;
        end
      end
      ST_S1_WR: begin
        cent_we   = 1'b1;
        state_nxt = k_last ? ST_S2_RD : ST_S1_RD;
      end
      ST_S2_RD: begin
        row_re    = 1'b1;
        cent_re   = 1'b1;
        state_nxt = ST_S2_EMIT;
      end
      ST_S2_EMIT: begin
        if (!in_k || out_free) begin
          row_we   = 1'b1;
          out_load = in_k;
          state_nxt = is_last_idx ? ST_IDLE : ST_S2_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      idx_r      <= '0;
      sidx_r     <= '0;
      cmp_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
      tot_r      <= '0;
      ovf_r      <= 1'b0;
      same_r     <= 1'b1;
      ch_r       <= 2'd0;
      pend_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_CLEAR: begin
          idx_r <= is_last_idx ? '0 : idx_r + IDXW'(1);
        end
        ST_IDLE: begin
          sidx_r     <= '0;
          cmp_vld_r  <= 1'b0;
          best_vld_r <= 1'b0;
        end
        ST_SEARCH: begin
          cmp_vld_r <= search_more;
          cmp_idx_r <= sidx_r[IDXW-1:0];
          if (search_more) begin
            sidx_r <= sidx_r + KW'(1);
          end
          if (cmp_vld_r && (!best_vld_r || (cand_d < best_d_r))) begin
            best_vld_r <= 1'b1;
            best_d_r   <= cand_d;
            best_r     <= cmp_idx_r;
          end
        end
        ST_ACC: begin
          if (tot_r[CNTW-1]) begin
            ovf_r <= 1'b1;
          end else begin
            tot_r <= tot_r + CNTW'(1);
          end
          if (item_r.last) begin
            same_r <= 1'b1;
            idx_r  <= '0;
            ch_r   <= 2'd0;
            pend_r <= 1'b0;
          end
        end
        ST_S1_DIV: begin
          if (row_cnt == '0) begin
            mean_r[0] <= cent_ch[0];
            mean_r[1] <= cent_ch[1];
            mean_r[2] <= cent_ch[2];
          end else if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (div_done) begin
            mean_r[ch_r] <= div_q;
            pend_r       <= 1'b0;
            ch_r         <= (ch_r == 2'd2) ? 2'd0 : ch_r + 2'd1;
          end
        end
        ST_S1_WR: begin
          if ({mean_r[2], mean_r[1], mean_r[0]} != cent_q) begin
            same_r <= 1'b0;
          end
          idx_r  <= k_last ? '0 : idx_r + IDXW'(1);
          ch_r   <= 2'd0;
          pend_r <= 1'b0;
        end
        ST_S2_EMIT: begin
          if (!in_k || out_free) begin
            idx_r <= is_last_idx ? '0 : idx_r + IDXW'(1);
            if (is_last_idx) begin
              tot_r <= '0;
              ovf_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid && q_item.cmd == CMD_PIXEL) begin
      item_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_cid_r  <= CID_W'(idx_r);
      o_m0_r   <= cent_ch[0];
      o_m1_r   <= cent_ch[1];
      o_m2_r   <= cent_ch[2];
      o_cnt_r  <= MCOUNT_W'(row_cnt);
      o_conv_r <= same_r;
      o_ovf_r  <= ovf_r;
      o_fin_r  <= k_last;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.cluster_id   = o_cid_r;
  assign out_bus.mean0        = o_m0_r;
  assign out_bus.mean1        = o_m1_r;
  assign out_bus.mean2        = o_m2_r;
  assign out_bus.member_count = o_cnt_r;
  assign out_bus.converged    = o_conv_r;
  assign out_bus.overflow     = o_ovf_r;
  assign out_bus.final_result = o_fin_r;

`ifndef ASSERT_OFF
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !tot_r[CNTW-1] || (tot_r[CNTW-2:0] == '0))
    else $error("pixel total beyond capacity");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (32'(best_r) < 32'(k)))
    else $error("nearest centroid outside active set");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_bus.ready))
    else $error("held result overwritten");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_start)
    else $error("divider restarted while busy");
`endif

endmodule

// ----- rtl/kmeans_color_pass.sv -----
// kmeans_color_pass: top level of one Lloyd k-means pass over RGB pixels.
// Depends on kcp_pkg, kcp_in_if, kcp_out_if, kcp_queue and kcp_engine.
//
// A load beat with an index below MAX_CLUSTERS writes a starting centroid
// (others are dropped); a pixel beat is compared against the k active
// centroids one distance per cycle. The pixel marked last starts the
// end-of-pass update: each active cluster with members divides its three
// sums bit-serially (an empty one keeps its centroid), then one result beat
// per active cluster is emitted in index order while all MAX_CLUSTERS
// accumulator rows are cleared. After reset a clearing pass over all
// MAX_CLUSTERS rows runs before the engine takes the first queued beat. A
// two-entry queue lets the input take up to two beats while the engine works.
module kmeans_color_pass import kcp_pkg::*; #(
  parameter int MAX_CLUSTERS     = 16,
  parameter int PIXEL_COUNT_BITS = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  kcp_in_if.sink           in_bus,
  kcp_out_if.source        out_bus
);

  logic [CFG_W-1:0] cfg_r;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(2);
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  kcp_queue #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  kcp_engine #(
    .MAX_CLUSTERS     (MAX_CLUSTERS),
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cluster_count (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_bus       (out_bus)
  );

endmodule
